[sv/avr_pkg.sv]
// ----------------------------------------------------------------------------
// avr_pkg - shared types and constants for the axis-angle vector rotator
// Holds the CORDIC gain and arctangent table, stage widths and beat records.
// ----------------------------------------------------------------------------
package avr_pkg;

   localparam int CordicSteps = 16;
   localparam int StepW       = 4;
   localparam int CordW       = 36;
   localparam int PhaseW      = 33;

   localparam logic signed [CordW-1:0] CORDIC_GAIN = 36'sd652032874;

   // atan(2^-i) in phase units (2^32 = one turn)
   function automatic logic signed [PhaseW-1:0] atan_lut(input logic [StepW-1:0] idx);
      logic signed [PhaseW-1:0] val;
      case (idx)
         4'd0:    val = 33'sd536870912;
         4'd1:    val = 33'sd316933406;
         4'd2:    val = 33'sd167458907;
         4'd3:    val = 33'sd85004756;
         4'd4:    val = 33'sd42667331;
         4'd5:    val = 33'sd21354465;
         4'd6:    val = 33'sd10679838;
         4'd7:    val = 33'sd5339221;
         4'd8:    val = 33'sd2669651;
         4'd9:    val = 33'sd1334831;
         4'd10:   val = 33'sd667544;
         4'd11:   val = 33'sd333772;
         4'd12:   val = 33'sd166886;
         4'd13:   val = 33'sd83443;
         4'd14:   val = 33'sd41722;
         4'd15:   val = 33'sd20861;
         default: val = '0;
      endcase
      return val;
   endfunction

   // payload carried alongside the trig pipeline
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } side_type;

   // one CORDIC lane
   typedef struct packed {
      logic signed [CordW-1:0]  x;
      logic signed [CordW-1:0]  y;
      logic signed [PhaseW-1:0] z;
      logic                     neg;
   } cord_type;

   // beat leaving the trig front end
   typedef struct packed {
      side_type           side;
      logic signed [17:0] sin16;
      logic signed [17:0] cos16;
   } trig_type;

endpackage

[sv/axis_angle_vector_rotate.sv]
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate - Rodrigues rotation of a Q15.16 vector
// CORDIC sine/cosine, matrix build and matrix-vector product, output register.
// ----------------------------------------------------------------------------
// channel  dir  payload
// req_     in   pos_x, pos_y, pos_z, rot_angle, axis_x, axis_y, axis_z
// rsp_     out  out_x, out_y, out_z
//
// One beat per cycle while the output is not blocked; 25 register stages (18 trig, 6 rotate,
// 1 output), the first loaded at the accepting edge.
// The whole pipe advances when the output register is free or being drained.
// A stall freezes every stage; nothing is lost or repeated.
// Synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[31:0] pos_y[63:32] pos_z[95:64] rot_angle[111:96]
   // axis_x[127:112] axis_y[143:128] axis_z[159:144]
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0] out_y[63:32] out_z[95:64]
   output logic [95:0]  rsp_tdata
);

   logic              adv;
   avr_pkg::side_type side;
   logic              trig_valid;
   avr_pkg::trig_type trig;
   logic              rot_valid;
   logic signed [31:0] ox, oy, oz;
   logic              out_vld_ff;
   logic [95:0]       out_dat_ff;

   // pipe moves when output register empty or taken
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      side.pos_x  = req_tdata[31:0];
      side.pos_y  = req_tdata[63:32];
      side.pos_z  = req_tdata[95:64];
      side.axis_x = req_tdata[127:112];
      side.axis_y = req_tdata[143:128];
      side.axis_z = req_tdata[159:144];
   end

   avr_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_angle  (req_tdata[111:96]),
      .in_side   (side),
      .out_valid (trig_valid),
      .out_trig  (trig)
   );

   avr_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (trig_valid),
      .in_trig   (trig),
      .out_valid (rot_valid),
      .out_x     (ox),
      .out_y     (oy),
      .out_z     (oz)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_dat_ff <= {oz, oy, ox};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_dat_ff;

`ifndef ASSERT_OFF
   // a held result keeps its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("result changed under stall");
   // input is refused only while the output is blocked
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output backpressure");
   // a stalled pipe does not shift its trig valid
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(trig_valid))
      else $error("trig stage moved during stall");
`endif

endmodule

[sv/avr_cordic.sv]
// ----------------------------------------------------------------------------
// avr_cordic - pipelined sine/cosine front end
// One rotation step per stage, sixteen stages, plus fold and rounding stages.
// ----------------------------------------------------------------------------
module avr_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [15:0]  in_angle,
   input  avr_pkg::side_type   in_side,
   output logic                out_valid,
   output avr_pkg::trig_type   out_trig
);

   localparam int N = avr_pkg::CordicSteps;

   avr_pkg::cord_type  cord_ff  [N+1];
   avr_pkg::cord_type  cord_in  [N+1];
   avr_pkg::side_type  side_ff  [N+1];
   logic [N+1:0]       vld_ff;
   avr_pkg::trig_type  trig_ff;

   // quadrant fold of the input phase
   logic [31:0] phase;
   logic [31:0] phase_f;
   logic        fold;
   always_comb begin
      phase   = {in_angle, 16'h0000};
      fold    = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      phase_f = fold ? (phase + 32'h8000_0000) : phase;
      cord_in[0].x   = avr_pkg::CORDIC_GAIN;
      cord_in[0].y   = '0;
      cord_in[0].z   = {phase_f[31], phase_f};
      cord_in[0].neg = fold;
   end

   // rotation steps
   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [avr_pkg::CordW-1:0] xs, ys;
      always_comb begin
         xs = cord_ff[i].x >>> i;
         ys = cord_ff[i].y >>> i;
         cord_in[i+1].neg = cord_ff[i].neg;
         if (!cord_ff[i].z[avr_pkg::PhaseW-1]) begin
            cord_in[i+1].x = cord_ff[i].x - ys;
            cord_in[i+1].y = cord_ff[i].y + xs;
            cord_in[i+1].z = cord_ff[i].z - avr_pkg::atan_lut(avr_pkg::StepW'(i));
         end else begin
            cord_in[i+1].x = cord_ff[i].x + ys;
            cord_in[i+1].y = cord_ff[i].y - xs;
            cord_in[i+1].z = cord_ff[i].z + avr_pkg::atan_lut(avr_pkg::StepW'(i));
         end
      end
   end

   // sign fix and rounding to Q.16
   logic signed [avr_pkg::CordW-1:0] fx, fy, rx, ry;
   avr_pkg::trig_type trig_in;
   always_comb begin
      fx = cord_ff[N].neg ? -cord_ff[N].x : cord_ff[N].x;
      fy = cord_ff[N].neg ? -cord_ff[N].y : cord_ff[N].y;
      rx = (fx + avr_pkg::CordW'(8192)) >>> 14;
      ry = (fy + avr_pkg::CordW'(8192)) >>> 14;
      trig_in.side  = side_ff[N];
      trig_in.cos16 = rx[17:0];
      trig_in.sin16 = ry[17:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cord_ff[0] <= cord_in[0];
         side_ff[0] <= in_side;
         for (int k = 0; k < N; k++) begin
            cord_ff[k+1] <= cord_in[k+1];
            side_ff[k+1] <= side_ff[k];
         end
         trig_ff <= trig_in;
      end
   end

   assign out_valid = vld_ff[N+1];
   assign out_trig  = trig_ff;

endmodule

[sv/avr_rotate.sv]
// ----------------------------------------------------------------------------
// avr_rotate - matrix build and matrix-vector product
// Stages: axis products, matrix terms, rounded entries, entry*pos, row sums.
// ----------------------------------------------------------------------------
module avr_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  avr_pkg::trig_type  in_trig,
   output logic               out_valid,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic signed [31:0] out_z
);

   logic [5:0] vld_ff;

   // stage A: d*d, s*d, omc
   logic signed [31:0] dd_ff [3][3];
   logic signed [33:0] sd_ff [3];
   logic signed [18:0] omc_ff, ca_ff;
   logic signed [31:0] pa_ff [3];
   // stage B: exact Q.44 entries
   logic signed [63:0] m_ff  [3][3];
   logic signed [31:0] pb_ff [3];
   // stage C: rounded Q.24 entries
   logic signed [44:0] e_ff  [3][3];
   logic signed [31:0] pc_ff [3];
   // stage D/E: products split into low/high halves of the position
   logic signed [63:0] plo_ff [3][3];
   logic signed [63:0] phi_ff [3][3];
   logic signed [79:0] pr_ff  [3][3];
   // stage F: row sums
   logic signed [79:0] acc_ff [3];

   logic signed [15:0] d [3];
   assign d[0] = in_trig.side.axis_x;
   assign d[1] = in_trig.side.axis_y;
   assign d[2] = in_trig.side.axis_z;

   // linear term per entry: cos on the diagonal, skew-symmetric sine part
   // (lifted by 2^14) off it
   logic signed [63:0] lin_term [3][3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         lin_term[r][r] = 64'(ca_ff) <<< 28;
      end
      lin_term[0][1] = -(64'(sd_ff[2]) <<< 14);
      lin_term[0][2] =   64'(sd_ff[1]) <<< 14;
      lin_term[1][0] =   64'(sd_ff[2]) <<< 14;
      lin_term[1][2] = -(64'(sd_ff[0]) <<< 14);
      lin_term[2][0] = -(64'(sd_ff[1]) <<< 14);
      lin_term[2][1] =   64'(sd_ff[0]) <<< 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               dd_ff[r][k] <= d[r] * d[k];
            end
            sd_ff[r] <= in_trig.sin16 * d[r];
         end
         omc_ff   <= 19'sd65536 - 19'(in_trig.cos16);
         ca_ff    <= 19'(in_trig.cos16);
         pa_ff[0] <= in_trig.side.pos_x;
         pa_ff[1] <= in_trig.side.pos_y;
         pa_ff[2] <= in_trig.side.pos_z;

         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               m_ff[r][k] <= 64'(omc_ff * dd_ff[r][k]) + lin_term[r][k];
            end
            pb_ff[r] <= pa_ff[r];
         end

         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               e_ff[r][k] <= 45'((m_ff[r][k] + 64'sd524288) >>> 20);
            end
            pc_ff[r] <= pb_ff[r];
         end

         // entry times position, position split into 16-bit halves
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               plo_ff[r][k] <= 64'(e_ff[r][k] * $signed({1'b0, pc_ff[k][15:0]}));
               phi_ff[r][k] <= 64'(e_ff[r][k] * $signed(pc_ff[k][31:16]));
            end
         end

         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               pr_ff[r][k] <= (80'(phi_ff[r][k]) <<< 16) + 80'(plo_ff[r][k]);
            end
         end

         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= pr_ff[r][0] + pr_ff[r][1] + pr_ff[r][2];
         end
      end
   end

   // final rounding and saturation
   function automatic logic signed [31:0] sat_rnd(input logic signed [79:0] v);
      logic signed [79:0] t;
      t = (v + 80'sd8388608) >>> 24;
      if (t > 80'sd2147483647)       return 32'sh7fff_ffff;
      else if (t < -80'sd2147483648) return 32'sh8000_0000;
      else                           return t[31:0];
   endfunction

   assign out_valid = vld_ff[5];
   assign out_x = sat_rnd(acc_ff[0]);
   assign out_y = sat_rnd(acc_ff[1]);
   assign out_z = sat_rnd(acc_ff[2]);

endmodule

[bench/axis_angle_vector_rotate_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotate_tb - self-checking bench for the vector rotator
// Drives rotation beats with bursty gaps, stalls the result side on its own
// pattern, predicts each rotated vector in fixed point and compares in order.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotate_tb;

   localparam int NumRandom = 380;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] ang;
      logic signed [15:0] ax, ay, az;
   } rot_req_type;

   typedef struct {
      logic signed [31:0] x, y, z;
   } rot_vec_type;

   // fixed-point rotation predictor and in-order checker
   class rotate_scoreboard;
      rot_vec_type pending[$];
      int errors;

      static function longint floor_shift(longint v, int n);
         return v >>> n;
      endfunction

      static function longint round_shift(longint v, int n);
         return (v + (longint'(1) << (n - 1))) >>> n;
      endfunction

      static function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      // 16-step CORDIC, folded into [-pi/2, pi/2)
      static function void trig(logic [15:0] ang, output longint sn, output longint cs);
         longint arctan[16];
         logic [31:0] phase;
         longint x, y, z, xs, ys;
         bit flip;
         arctan = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10679838, 5339221, 2669651, 1334831, 667544, 333772,
                    166886, 83443, 41722, 20861};
         phase = {ang, 16'h0};
         flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
         if (flip) phase = phase + 32'h8000_0000;
         z = longint'($signed(phase));
         x = 652032874;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - arctan[i];
            end else begin
               x = x + ys; y = y - xs; z = z + arctan[i];
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         cs = round_shift(x, 14);
         sn = round_shift(y, 14);
      endfunction

      function rot_vec_type rotate(rot_req_type r);
         longint sn, cs, omc, acc;
         longint d[3], p[3], m[3][3];
         rot_vec_type o;
         trig(r.ang, sn, cs);
         omc = 65536 - cs;
         d = '{r.ax, r.ay, r.az};
         p = '{r.px, r.py, r.pz};
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               m[i][k] = omc * d[i] * d[k] + ((i == k) ? cs * (longint'(1) << 28) : 0);
         m[0][1] -= sn * d[2] * 16384;
         m[0][2] += sn * d[1] * 16384;
         m[1][0] += sn * d[2] * 16384;
         m[1][2] -= sn * d[0] * 16384;
         m[2][0] -= sn * d[1] * 16384;
         m[2][1] += sn * d[0] * 16384;
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += round_shift(m[i][k], 20) * p[k];
            acc = clamp32(round_shift(acc, 24));
            if (i == 0) o.x = acc[31:0];
            else if (i == 1) o.y = acc[31:0];
            else o.z = acc[31:0];
         end
         return o;
      endfunction

      function void note_input(rot_req_type r);
         pending.push_back(rotate(r));
      endfunction

      function void check_result(logic [95:0] data);
         rot_vec_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, data);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (data[31:0] !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $time, e.x, data[31:0]);
            errors++;
         end
         if (data[63:32] !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $time, e.y, data[63:32]);
            errors++;
         end
         if (data[95:64] !== e.z) begin
            $display("%0t: out_z expected %h actual %h", $time, e.z, data[95:64]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [159:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;

   rotate_scoreboard board = new();
   bit hold_off = 1'b0;
   bit sending_done = 1'b0;

   axis_angle_vector_rotate dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // send one beat; valid stays high from the previous beat when back to back
   task automatic send_beat(rot_req_type r);
      req_tdata <= {r.az, r.ay, r.ax, r.ang, r.pz, r.py, r.px};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_input(r);
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($urandom);
         default: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
      endcase
   endfunction

   function automatic rot_req_type rand_req();
      rot_req_type r;
      r.px = rand_pos(); r.py = rand_pos(); r.pz = rand_pos();
      r.ang = 16'($urandom);
      r.ax = rand_axis(); r.ay = rand_axis(); r.az = rand_axis();
      return r;
   endfunction

   function automatic rot_req_type mk(int px, int py, int pz, int ang, int ax, int ay, int az);
      rot_req_type r;
      r.px = px; r.py = py; r.pz = pz; r.ang = ang[15:0];
      r.ax = ax[15:0]; r.ay = ay[15:0]; r.az = az[15:0];
      return r;
   endfunction

   // result side: random stall pattern plus one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_off) rsp_tready <= 1'b0;
         else if ((cyc / 40) % 3 == 0) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   initial begin
      rot_req_type dir[$];
      int cnt;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: angle extremes, axis extremes, zero and non-unit axes, saturation
      dir.push_back(mk(65536, 0, 0, 0, 0, 0, 16384));
      dir.push_back(mk(65536, 0, 0, 16384, 0, 0, 16384));
      dir.push_back(mk(65536, 65536, 0, -32768, 0, 0, 16384));
      dir.push_back(mk(65536, 0, 65536, 32767, 16384, 0, 0));
      dir.push_back(mk(0, 65536, 0, -16384, 0, -16384, 0));
      dir.push_back(mk(65536, 0, 0, 8192, 0, 0, -16384));
      dir.push_back(mk(65536, 65536, 65536, 21845, 9459, 9459, 9459));
      dir.push_back(mk(131072, -65536, 3, 5000, 0, 0, 0));
      dir.push_back(mk(65536, 65536, 65536, 1, 32767, -32768, 32767));
      dir.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 16384, 16384, 16384));
      dir.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000, 0, 16384, 16384, 16384));
      dir.push_back(mk(32'h7fffffff, 32'h80000000, 0, 16384, 0, 0, 16384));
      dir.push_back(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, -1, 0, 16384, 0));
      dir.push_back(mk(-1, -1, -1, 32768, -16384, 0, 0));
      dir.push_back(mk(123456, -654321, 999, 16383, 11585, -11585, 0));
      dir.push_back(mk(123456, -654321, 999, -16385, 0, 11585, 11585));
      dir.push_back(mk(0, 0, 0, 12345, 16384, 0, 0));
      foreach (dir[i]) send_beat(dir[i]);

      // sender pauses until everything has drained
      idle_sender(1);
      while (board.pending.size() != 0) @(negedge clock);
      @(negedge clock);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (80) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 50; i++) send_beat(rand_req());
      join

      // random bursts with gaps
      cnt = 0;
      while (cnt < NumRandom) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst; i++) send_beat(rand_req());
         cnt += burst;
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
   end

   // end of run
   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[axis_angle_vector_rotate] OK");
      else
         $display("[axis_angle_vector_rotate] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[axis_angle_vector_rotate] ERROR");
      $finish;
   end

endmodule
